### rtl/core/cascaded_first_order_iir_macros.svh
// Assertion macros for the cascaded first-order IIR filter.
`ifndef CASCADED_FIRST_ORDER_IIR_MACROS_SVH
`define CASCADED_FIRST_ORDER_IIR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define IIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cfoiir_pkg.sv
// Types, constants and microcode ROM of the cascaded first-order IIR filter.
package cfoiir_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CHAN_BITS   = 4;
  localparam int MODE_BITS   = 2;
  localparam int STATE_BITS  = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_BITS   = STATE_BITS + 2;
  localparam int PROD_BITS   = COEF_BITS + 1 + DIFF_BITS;
  localparam int MULQ_BITS   = PROD_BITS - COEF_BITS;
  localparam int SUM_BITS    = MULQ_BITS + 1;
  localparam int PC_BITS     = 4;
  localparam int REG_BITS    = 2;

  localparam logic [COEF_BITS-1:0] ALPHA_RESET = COEF_BITS'(32768);

  typedef enum logic [REG_BITS-1:0] {
    REG_FILTER_MODE = 2'd0,
    REG_ALPHA_LOW   = 2'd1,
    REG_ALPHA_HIGH  = 2'd2,
    REG_ALPHA_DC    = 2'd3
  } reg_index_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOWPASS  = 2'd0,
    MODE_HIGHPASS = 2'd1,
    MODE_BANDPASS = 2'd2,
    MODE_DC_BAND  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_DIFF_LOW,
    ACT_DIFF_HIGH,
    ACT_DIFF_DC,
    ACT_MUL_LOW,
    ACT_MUL_HIGH,
    ACT_MUL_DC,
    ACT_FIN_LOW,
    ACT_FIN_HIGH,
    ACT_FIN_DC
  } act_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_DISPATCH,
    SEQ_END
  } seq_t;

  typedef struct packed {
    act_t               act;
    seq_t               seq;
    logic [PC_BITS-1:0] target;
  } ctrl_t;

  localparam logic [PC_BITS-1:0] P_DISPATCH  = 4'd0;
  localparam logic [PC_BITS-1:0] P_BLOCK     = 4'd1;
  localparam logic [PC_BITS-1:0] P_LOWPASS   = 4'd2;
  localparam logic [PC_BITS-1:0] P_HIGHPASS  = 4'd5;
  localparam logic [PC_BITS-1:0] P_BANDPASS  = 4'd8;
  localparam logic [PC_BITS-1:0] P_DC_BAND   = 4'd11;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_start;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
  } out_word_t;

  typedef struct packed {
    logic signed [STATE_BITS-1:0] value;
    logic                         hit;
  } clip_t;

  function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_t c;
    c = '{act: ACT_NOP, seq: SEQ_END, target: P_DISPATCH};
    case (pc)
      4'd0:  c = '{act: ACT_NOP,       seq: SEQ_DISPATCH, target: P_DISPATCH};
      4'd1:  c = '{act: ACT_LOAD,      seq: SEQ_END,      target: P_DISPATCH};
      4'd2:  c = '{act: ACT_DIFF_LOW,  seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd3:  c = '{act: ACT_MUL_LOW,   seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd4:  c = '{act: ACT_FIN_LOW,   seq: SEQ_END,      target: P_DISPATCH};
      4'd5:  c = '{act: ACT_DIFF_HIGH, seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd6:  c = '{act: ACT_MUL_HIGH,  seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd7:  c = '{act: ACT_FIN_HIGH,  seq: SEQ_END,      target: P_DISPATCH};
      4'd8:  c = '{act: ACT_DIFF_LOW,  seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd9:  c = '{act: ACT_MUL_LOW,   seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd10: c = '{act: ACT_FIN_LOW,   seq: SEQ_JUMP,     target: P_HIGHPASS};
      4'd11: c = '{act: ACT_DIFF_DC,   seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd12: c = '{act: ACT_MUL_DC,    seq: SEQ_NEXT,     target: P_DISPATCH};
      4'd13: c = '{act: ACT_FIN_DC,    seq: SEQ_JUMP,     target: P_BANDPASS};
      default: c = '{act: ACT_NOP,     seq: SEQ_END,      target: P_DISPATCH};
    endcase
    return c;
  endfunction

  function automatic logic [PC_BITS-1:0] mode_entry(input mode_t mode);
    logic [PC_BITS-1:0] p;
    p = P_LOWPASS;
    case (mode)
      MODE_LOWPASS:  p = P_LOWPASS;
      MODE_HIGHPASS: p = P_HIGHPASS;
      MODE_BANDPASS: p = P_BANDPASS;
      MODE_DC_BAND:  p = P_DC_BAND;
      default:       p = P_LOWPASS;
    endcase
    return p;
  endfunction

  function automatic clip_t clip_state(input logic signed [SUM_BITS-1:0] v);
    clip_t r;
    logic signed [SUM_BITS-1:0] back;
    back = SUM_BITS'($signed(v[STATE_BITS-1:0]));
    r.hit = (back != v);
    if (!r.hit) begin
      r.value = v[STATE_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r.value = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/core/cascaded_first_order_iir.sv
// Top level of the cascaded first-order IIR filter with its microcoded datapath.
// One word in gives one word out, in order, for the channel it names. A small
// microcode program steers one shared multiplier through three steps per filter
// stage (difference, coefficient product, clip and state write-back), after one
// dispatch step that picks the program from the mode and the block-start flag.
// The input is stalled while a word runs its program and is taken again once
// its result has been posted, so no new word enters before the last is done.
// Channel state lives in five single-port arrays of CHANNELS entries read once
// per word; a channel must see a block-start word before its state is meaningful.
`include "cascaded_first_order_iir_macros.svh"

module cascaded_first_order_iir #(
  parameter int CHANNELS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cfoiir_pkg::REG_BITS-1:0]     cfg_index,
  input  logic [cfoiir_pkg::COEF_BITS-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cfoiir_pkg::in_word_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cfoiir_pkg::out_word_t               out_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SB    = cfoiir_pkg::STATE_BITS;
  localparam int DB    = cfoiir_pkg::DIFF_BITS;
  localparam int PB    = cfoiir_pkg::PROD_BITS;
  localparam int QB    = cfoiir_pkg::MULQ_BITS;
  localparam int UB    = cfoiir_pkg::SUM_BITS;
  localparam int CB    = cfoiir_pkg::COEF_BITS;
  localparam int FB    = cfoiir_pkg::FRAC_BITS;

  cfoiir_pkg::mode_t           mode;
  logic [CB-1:0]               alpha_low;
  logic [CB-1:0]               alpha_high;
  logic [CB-1:0]               alpha_dc;

  logic                        busy;
  logic [cfoiir_pkg::PC_BITS-1:0] pc;
  cfoiir_pkg::ctrl_t           ctrl;
  logic                        accept;
  logic                        fire;

  logic [cfoiir_pkg::CHAN_BITS-1:0] chan;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            idx_in;
  logic                        blk;
  logic                        flag;
  logic signed [SB-1:0]        x;
  logic signed [DB-1:0]        d;
  logic signed [QB-1:0]        p;

  logic signed [SB-1:0]        rd_low;
  logic signed [SB-1:0]        rd_dc_in;
  logic signed [SB-1:0]        rd_dc_out;
  logic signed [SB-1:0]        rd_high_in;
  logic signed [SB-1:0]        rd_high_out;

  logic signed [SB-1:0]        low_mem     [CHANNELS];
  logic signed [SB-1:0]        dc_in_mem   [CHANNELS];
  logic signed [SB-1:0]        dc_out_mem  [CHANNELS];
  logic signed [SB-1:0]        high_in_mem [CHANNELS];
  logic signed [SB-1:0]        high_out_mem[CHANNELS];

  logic [CB-1:0]               coef;
  logic signed [PB-1:0]        prod;
  logic signed [DB-1:0]        diff;
  logic signed [UB-1:0]        sum;
  cfoiir_pkg::clip_t           y;
  logic signed [SB-1:0]        res_value;
  logic                        res_sat;

  always_comb begin
    idx_in = '0;
    for (int i = 0; i < (1 << cfoiir_pkg::CHAN_BITS); i++) begin
      if (in_data.channel == cfoiir_pkg::CHAN_BITS'(i)) begin
        idx_in = IDX_W'(i % CHANNELS);
      end
    end
  end

  assign ctrl     = cfoiir_pkg::ucode(pc);
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign fire     = busy && !(ctrl.seq == cfoiir_pkg::SEQ_END && out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= cfoiir_pkg::MODE_LOWPASS;
      alpha_low  <= cfoiir_pkg::ALPHA_RESET;
      alpha_high <= cfoiir_pkg::ALPHA_RESET;
      alpha_dc   <= cfoiir_pkg::ALPHA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cfoiir_pkg::REG_FILTER_MODE: mode       <= cfoiir_pkg::mode_t'(cfg_data[1:0]);
        cfoiir_pkg::REG_ALPHA_LOW:   alpha_low  <= cfg_data;
        cfoiir_pkg::REG_ALPHA_HIGH:  alpha_high <= cfg_data;
        cfoiir_pkg::REG_ALPHA_DC:    alpha_dc   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.act)
      cfoiir_pkg::ACT_MUL_HIGH: coef = alpha_high;
      cfoiir_pkg::ACT_MUL_DC:   coef = alpha_dc;
      default:                  coef = alpha_low;
    endcase
    prod = $signed({1'b0, coef}) * d;

    case (ctrl.act)
      cfoiir_pkg::ACT_DIFF_HIGH: diff = DB'(rd_high_out) + DB'(x) - DB'(rd_high_in);
      cfoiir_pkg::ACT_DIFF_DC:   diff = DB'(rd_dc_out) + DB'(x) - DB'(rd_dc_in);
      default:                   diff = DB'(x) - DB'(rd_low);
    endcase

    if (ctrl.act == cfoiir_pkg::ACT_FIN_LOW) begin
      sum = UB'(rd_low) + UB'(p);
    end else begin
      sum = UB'(p);
    end
    y = cfoiir_pkg::clip_state(sum);

    if (ctrl.act == cfoiir_pkg::ACT_LOAD) begin
      res_value = x;
      res_sat   = 1'b0;
    end else begin
      res_value = y.value;
      res_sat   = flag | y.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= cfoiir_pkg::P_DISPATCH;
      out_valid <= 1'b0;
    end else begin
      if (fire && ctrl.seq == cfoiir_pkg::SEQ_END) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= cfoiir_pkg::P_DISPATCH;
      end else if (fire) begin
        case (ctrl.seq)
          cfoiir_pkg::SEQ_NEXT:     pc <= pc + 1'b1;
          cfoiir_pkg::SEQ_JUMP:     pc <= ctrl.target;
          cfoiir_pkg::SEQ_DISPATCH: pc <= blk ? cfoiir_pkg::P_BLOCK
                                              : cfoiir_pkg::mode_entry(mode);
          cfoiir_pkg::SEQ_END:      busy <= 1'b0;
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan <= in_data.channel;
      idx  <= idx_in;
      blk  <= in_data.block_start;
      flag <= 1'b0;
      x    <= {in_data.sample_in, {FB{1'b0}}};
    end else if (fire) begin
      case (ctrl.act)
        cfoiir_pkg::ACT_DIFF_LOW,
        cfoiir_pkg::ACT_DIFF_HIGH,
        cfoiir_pkg::ACT_DIFF_DC: d <= diff;
        cfoiir_pkg::ACT_MUL_LOW,
        cfoiir_pkg::ACT_MUL_HIGH,
        cfoiir_pkg::ACT_MUL_DC: p <= prod[PB-1:CB];
        cfoiir_pkg::ACT_FIN_LOW,
        cfoiir_pkg::ACT_FIN_HIGH,
        cfoiir_pkg::ACT_FIN_DC: begin
          x    <= y.value;
          flag <= flag | y.hit;
        end
        default: ;
      endcase
    end
    if (fire && ctrl.seq == cfoiir_pkg::SEQ_END) begin
      out_data.channel_out <= chan;
      out_data.sample_out  <= res_value[SB-1:FB];
      out_data.saturated   <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_low      <= low_mem[idx_in];
      rd_dc_in    <= dc_in_mem[idx_in];
      rd_dc_out   <= dc_out_mem[idx_in];
      rd_high_in  <= high_in_mem[idx_in];
      rd_high_out <= high_out_mem[idx_in];
    end
    if (fire) begin
      case (ctrl.act)
        cfoiir_pkg::ACT_LOAD: begin
          low_mem[idx]      <= x;
          dc_in_mem[idx]    <= x;
          dc_out_mem[idx]   <= x;
          high_in_mem[idx]  <= x;
          high_out_mem[idx] <= x;
        end
        cfoiir_pkg::ACT_FIN_LOW: low_mem[idx] <= y.value;
        cfoiir_pkg::ACT_FIN_HIGH: begin
          high_in_mem[idx]  <= x;
          high_out_mem[idx] <= y.value;
        end
        cfoiir_pkg::ACT_FIN_DC: begin
          dc_in_mem[idx]  <= x;
          dc_out_mem[idx] <= y.value;
        end
        default: ;
      endcase
    end
  end

  `IIR_ASSERT_NEXT(a_accept_dispatch, accept, busy && pc == cfoiir_pkg::P_DISPATCH, "accepted word did not start at dispatch")
  `IIR_ASSERT_NEXT(a_stay_busy, busy && ctrl.seq != cfoiir_pkg::SEQ_END, busy, "sequencer left a program before its end step")
  `IIR_ASSERT_NEXT(a_block_clean, fire && ctrl.act == cfoiir_pkg::ACT_LOAD, out_valid && !out_data.saturated, "block-start word reported saturation")
  `IIR_ASSERT_NOW(a_no_fire_idle, !busy, !fire, "microcode step executed while idle")

endmodule
